[design/tpz_pkg.sv]
`timescale 1ns / 1ps
// Package for the torus point plotter: types, codes, constants and helper functions.
// No dependencies; tpz_front, tpz_cmd_queue, tpz_back, the top level and the testbench import it.
package tpz_pkg;

    localparam int SCREEN_COLS_DEF = 80;
    localparam int SCREEN_ROWS_DEF = 22;
    localparam int CELL_COUNT_DEF  = 1760;

    localparam int VAL_W   = 22;
    localparam int PROD_W  = 44;
    localparam int PROJ_W  = 48;
    localparam int POS_W   = 19;
    localparam int CELL_W  = 16;
    localparam int DEPTH_W = 16;
    localparam int SHADE_W = 4;
    localparam int STEP_CNT = 24;

    localparam logic [SHADE_W-1:0] BLANK_SHADE = 4'd12;
    localparam logic [SHADE_W-1:0] MAX_SHADE   = 4'd11;
    localparam int COL_CENTER = 40;
    localparam int ROW_CENTER = 12;
    localparam int COL_SCALE_SH_HI = 5;
    localparam int COL_SCALE_SH_LO = 1;
    localparam int ROW_SCALE_SH_HI = 4;
    localparam int ROW_SCALE_SH_LO = 0;
    localparam int VIEW_BIAS  = 5 * 16384;
    localparam int RING_BIAS  = 2 * 16384;
    localparam int SAT_DEN    = 8192;
    localparam logic [VAL_W-1:0] REM_INIT = VAL_W'(8192);
    localparam logic [7:0] BLANK_CHAR = 8'd32;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_PLOT  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_SIN_A = 2'd0,
        REG_COS_A = 2'd1,
        REG_SIN_B = 2'd2,
        REG_COS_B = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLEAR,
        OP_PLOT,
        OP_READ,
        OP_BLANK
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [CELL_W-1:0]    loc;
        logic [DEPTH_W-1:0]   depth;
        logic [SHADE_W-1:0]   shade;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] sin_a;
        logic signed [15:0] cos_a;
        logic signed [15:0] sin_b;
        logic signed [15:0] cos_b;
    } t_rot;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_PROJ,
        F_CELL,
        F_SEND
    } t_fstate;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_WAIT
    } t_bstate;

    typedef enum logic [4:0] {
        S_CH   = 5'd0,
        S_FE   = 5'd1,
        S_FG   = 5'd2,
        S_LH   = 5'd3,
        S_CHG  = 5'd4,
        S_CHE  = 5'd5,
        S_CD   = 5'd6,
        S_LD   = 5'd7,
        S_T    = 5'd8,
        S_DEN  = 5'd9,
        S_P1   = 5'd10,
        S_P2   = 5'd11,
        S_P3   = 5'd12,
        S_P4   = 5'd13,
        S_CDG  = 5'd14,
        S_CDE  = 5'd15,
        S_LDN  = 5'd16,
        S_U    = 5'd17,
        S_V    = 5'd18,
        S_W    = 5'd19,
        S_WM   = 5'd20,
        S_LUM  = 5'd21,
        S_PU   = 5'd22,
        S_PV   = 5'd23
    } t_step;

    function automatic logic [7:0] shade_char(logic [SHADE_W-1:0] s);
        logic [7:0] c;
        case (s)
            4'd0:    c = 8'h2E;
            4'd1:    c = 8'h2C;
            4'd2:    c = 8'h2D;
            4'd3:    c = 8'h7E;
            4'd4:    c = 8'h3A;
            4'd5:    c = 8'h3B;
            4'd6:    c = 8'h3D;
            4'd7:    c = 8'h21;
            4'd8:    c = 8'h2A;
            4'd9:    c = 8'h23;
            4'd10:   c = 8'h24;
            4'd11:   c = 8'h40;
            default: c = BLANK_CHAR;
        endcase
        return c;
    endfunction

    function automatic logic signed [POS_W-1:0] trunc29(logic signed [PROJ_W-1:0] x);
        logic [PROJ_W-1:0] mag;
        logic [POS_W-1:0]  q;
        mag = x[PROJ_W-1] ? PROJ_W'(-x) : PROJ_W'(x);
        q   = POS_W'(mag >> 29);
        return x[PROJ_W-1] ? $signed(POS_W'(-q)) : $signed(q);
    endfunction

endpackage

[design/tpz_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tpz_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1760
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[design/tpz_front.sv]
`timescale 1ns / 1ps
// Front end: takes items, runs the rotation, projection and shading math on a shared
// multiplier and a bit-serial divider, and issues one command per item. Uses tpz_pkg.
module tpz_front import tpz_pkg::*; #(
    parameter int SCREEN_COLS = SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
    parameter int CELL_COUNT  = CELL_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_action            i_action,
    input  logic [10:0]        i_cell_index,
    input  logic signed [15:0] i_sin_phi,
    input  logic signed [15:0] i_cos_phi,
    input  logic signed [15:0] i_sin_theta,
    input  logic signed [15:0] i_cos_theta,
    input  t_rot               i_rot,
    output logic               o_ready,
    output t_cmd               o_cmd,
    output logic               o_cmd_push,
    input  logic               i_cmd_full
);
    localparam logic signed [PROJ_W-1:0] COL_BASE = PROJ_W'(COL_CENTER) <<< 29;
    localparam logic signed [PROJ_W-1:0] ROW_BASE = PROJ_W'(ROW_CENTER) <<< 29;

    t_fstate r_state, n_state;
    t_step   r_step, n_step;

    logic signed [15:0]        r_c, r_l, r_f, r_d;
    logic signed [16:0]        r_h;
    logic signed [VAL_W-1:0]   r_val [0:STEP_CNT-1];
    logic [VAL_W-1:0]          r_rem;
    logic [DEPTH_W-1:0]        r_dq;
    logic [3:0]                r_bit;
    logic signed [PROD_W-1:0]  r_pu, r_pv;
    logic signed [POS_W-1:0]   r_col, r_row;
    t_cmd                      r_cmd;

    logic signed [VAL_W-1:0]   mul_a, mul_b, step_res;
    logic signed [PROD_W-1:0]  prod;
    logic signed [VAL_W-1:0]   den;
    logic                      den_le0, den_sat, ge;
    logic [VAL_W-1:0]          rem2;
    logic signed [PROJ_W-1:0]  pu_w, pv_w, xcol, xrow;
    logic                      on_screen, cell_ok;
    logic [CELL_W-1:0]         cell16;
    logic signed [VAL_W-1:0]   lum, lum_sh;
    logic [SHADE_W-1:0]        shade;
    logic                      idx_ok;
    t_cmd                      acc_cmd, cell_cmd;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_step)
            S_CH:  begin mul_a = VAL_W'(r_c);          mul_b = VAL_W'(r_h);       end
            S_FE:  begin mul_a = VAL_W'(r_f);          mul_b = VAL_W'(i_rot.sin_a); end
            S_FG:  begin mul_a = VAL_W'(r_f);          mul_b = VAL_W'(i_rot.cos_a); end
            S_LH:  begin mul_a = VAL_W'(r_l);          mul_b = VAL_W'(r_h);       end
            S_CHG: begin mul_a = r_val[S_CH];          mul_b = VAL_W'(i_rot.cos_a); end
            S_CHE: begin mul_a = r_val[S_CH];          mul_b = VAL_W'(i_rot.sin_a); end
            S_CD:  begin mul_a = VAL_W'(r_c);          mul_b = VAL_W'(r_d);       end
            S_LD:  begin mul_a = VAL_W'(r_l);          mul_b = VAL_W'(r_d);       end
            S_P1:  begin mul_a = r_val[S_LH];          mul_b = VAL_W'(i_rot.cos_b); end
            S_P2:  begin mul_a = r_val[S_T];           mul_b = VAL_W'(i_rot.sin_b); end
            S_P3:  begin mul_a = r_val[S_LH];          mul_b = VAL_W'(i_rot.sin_b); end
            S_P4:  begin mul_a = r_val[S_T];           mul_b = VAL_W'(i_rot.cos_b); end
            S_CDG: begin mul_a = r_val[S_CD];          mul_b = VAL_W'(i_rot.cos_a); end
            S_CDE: begin mul_a = r_val[S_CD];          mul_b = VAL_W'(i_rot.sin_a); end
            S_LDN: begin mul_a = r_val[S_LD];          mul_b = VAL_W'(i_rot.sin_b); end
            S_WM:  begin mul_a = r_val[S_W];           mul_b = VAL_W'(i_rot.cos_b); end
            S_PU:  begin mul_a = VAL_W'({1'b0, r_dq}); mul_b = r_val[S_U];        end
            S_PV:  begin mul_a = VAL_W'({1'b0, r_dq}); mul_b = r_val[S_V];        end
            default: ;
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb begin
        unique case (r_step)
            S_T:   step_res = r_val[S_CHG] - r_val[S_FE];
            S_DEN: step_res = r_val[S_CHE] + r_val[S_FG] + VAL_W'(VIEW_BIAS);
            S_U:   step_res = r_val[S_P1] - r_val[S_P2];
            S_V:   step_res = r_val[S_P3] + r_val[S_P4];
            S_W:   step_res = r_val[S_FE] - r_val[S_CDG];
            S_LUM: step_res = r_val[S_WM] - r_val[S_CDE] - r_val[S_FG] - r_val[S_LDN];
            default: step_res = VAL_W'(prod >>> 14);
        endcase
    end

    assign den     = r_val[S_DEN];
    assign den_le0 = (den <= 0);
    assign den_sat = (den <= VAL_W'(SAT_DEN));
    assign rem2    = {r_rem[VAL_W-2:0], 1'b0};
    assign ge      = (rem2 >= VAL_W'(den));

    assign pu_w = PROJ_W'(r_pu);
    assign pv_w = PROJ_W'(r_pv);
    assign xcol = COL_BASE + (pu_w <<< COL_SCALE_SH_HI) - (pu_w <<< COL_SCALE_SH_LO);
    assign xrow = ROW_BASE + (pv_w <<< ROW_SCALE_SH_HI) - (pv_w <<< ROW_SCALE_SH_LO);

    assign on_screen = (r_col > 0) && (r_col < $signed(POS_W'(SCREEN_COLS)))
                    && (r_row > 0) && (r_row < $signed(POS_W'(SCREEN_ROWS)));
    assign cell16  = CELL_W'(r_col) + CELL_W'(r_row) * CELL_W'(SCREEN_COLS);
    assign cell_ok = ({1'b0, cell16} < (CELL_W + 1)'(CELL_COUNT));

    assign lum    = r_val[S_LUM];
    assign lum_sh = lum >>> 11;
    always_comb begin
        if (lum <= 0) begin
            shade = '0;
        end else if (lum_sh > VAL_W'(MAX_SHADE)) begin
            shade = MAX_SHADE;
        end else begin
            shade = lum_sh[SHADE_W-1:0];
        end
    end

    assign idx_ok = ({5'd0, i_cell_index} < CELL_W'(CELL_COUNT));

    always_comb begin
        acc_cmd       = '0;
        acc_cmd.loc   = {5'd0, i_cell_index};
        unique case (i_action)
            ACT_CLEAR: acc_cmd.op = idx_ok ? OP_CLEAR : OP_NOP;
            ACT_READ:  acc_cmd.op = idx_ok ? OP_READ : OP_BLANK;
            default:   acc_cmd.op = OP_NOP;
        endcase
        cell_cmd       = '0;
        cell_cmd.op    = (on_screen && cell_ok) ? OP_PLOT : OP_NOP;
        cell_cmd.loc   = cell16;
        cell_cmd.depth = r_dq;
        cell_cmd.shade = shade;
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_ready    = 1'b0;
        o_cmd_push = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_accept) begin
                    if (i_action == ACT_PLOT) begin
                        n_state = F_MUL;
                        n_step  = S_CH;
                    end else begin
                        n_state = F_SEND;
                    end
                end
            end
            F_MUL: begin
                if (r_step == S_LUM) begin
                    n_state = F_DIV;
                end else if (r_step == S_PV) begin
                    n_state = F_PROJ;
                end else begin
                    n_step = t_step'(r_step + 5'd1);
                end
            end
            F_DIV: begin
                if (den_le0) begin
                    n_state = F_SEND;
                end else if (den_sat || r_bit == 4'd15) begin
                    n_state = F_MUL;
                    n_step  = S_PU;
                end
            end
            F_PROJ: n_state = F_CELL;
            F_CELL: n_state = F_SEND;
            F_SEND: begin
                o_cmd_push = !i_cmd_full;
                if (!i_cmd_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= S_CH;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
        if (r_state == F_IDLE && i_accept) begin
            r_c   <= i_sin_phi;
            r_l   <= i_cos_phi;
            r_f   <= i_sin_theta;
            r_d   <= i_cos_theta;
            r_h   <= 17'(i_cos_theta) + 17'(RING_BIAS);
            r_cmd <= acc_cmd;
        end
        if (r_state == F_MUL) begin
            r_val[r_step] <= step_res;
            if (r_step == S_PU) begin
                r_pu <= prod;
            end
            if (r_step == S_PV) begin
                r_pv <= prod;
            end
            if (r_step == S_LUM) begin
                r_rem <= REM_INIT;
                r_bit <= '0;
            end
        end
        if (r_state == F_DIV) begin
            if (den_le0) begin
                r_cmd <= '0;
            end else if (den_sat) begin
                r_dq <= '1;
            end else begin
                r_rem <= ge ? rem2 - VAL_W'(den) : rem2;
                r_dq  <= {r_dq[DEPTH_W-2:0], ge};
                r_bit <= r_bit + 4'd1;
            end
        end
        if (r_state == F_PROJ) begin
            r_col <= trunc29(xcol);
            r_row <= trunc29(xrow);
        end
        if (r_state == F_CELL) begin
            r_cmd <= cell_cmd;
        end
    end

    assign o_cmd = r_cmd;
endmodule

[design/tpz_cmd_queue.sv]
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the back end.
// Uses tpz_pkg for the command type.
module tpz_cmd_queue import tpz_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_valid
);
    t_cmd       r_mem [0:1];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule

[design/tpz_back.sv]
`timescale 1ns / 1ps
// Back end: owns the depth and shade store, runs the clearing pass, executes commands
// and holds the result register. Uses tpz_pkg and tpz_ram.
module tpz_back import tpz_pkg::*; #(
    parameter int CELL_COUNT = CELL_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_valid,
    output logic       o_cmd_pop,
    input  logic       i_pop,
    output logic       o_res_valid,
    output logic       o_drawn,
    output logic [7:0] o_char_code,
    output logic       o_clearing
);
    localparam int AW = $clog2(CELL_COUNT);
    localparam int WW = DEPTH_W + SHADE_W;

    t_bstate          r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    t_cmd             r_cmd, n_cmd;
    logic             r_res_valid, n_res_valid;
    logic             r_drawn, n_drawn;
    logic [7:0]       r_char, n_char;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [WW-1:0]    wdata, rdata;
    logic [DEPTH_W-1:0] rd_depth;
    logic [SHADE_W-1:0] rd_shade;

    tpz_ram #(
        .WIDTH (WW),
        .DEPTH (CELL_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_depth = rdata[WW-1:SHADE_W];
    assign rd_shade = rdata[SHADE_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cmd       = r_cmd;
        n_res_valid = r_res_valid;
        n_drawn     = r_drawn;
        n_char      = r_char;
        o_cmd_pop   = 1'b0;
        we          = 1'b0;
        waddr       = AW'(i_cmd.loc);
        wdata       = {{DEPTH_W{1'b0}}, BLANK_SHADE};
        raddr       = AW'(i_cmd.loc);
        if (i_pop && r_res_valid) begin
            n_res_valid = 1'b0;
        end
        unique case (r_state)
            B_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(CELL_COUNT - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_cmd_valid && !r_res_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_drawn   = 1'b0;
                    n_char    = 8'd0;
                    unique case (i_cmd.op) inside
                        OP_PLOT, OP_READ: n_state = B_WAIT;
                        OP_CLEAR: begin
                            we          = 1'b1;
                            n_res_valid = 1'b1;
                        end
                        OP_BLANK: begin
                            n_char      = BLANK_CHAR;
                            n_res_valid = 1'b1;
                        end
                        default: n_res_valid = 1'b1;
                    endcase
                end
            end
            B_WAIT: begin
                n_state     = B_IDLE;
                n_res_valid = 1'b1;
                if (r_cmd.op == OP_PLOT) begin
                    if (r_cmd.depth > rd_depth) begin
                        we      = 1'b1;
                        waddr   = AW'(r_cmd.loc);
                        wdata   = {r_cmd.depth, r_cmd.shade};
                        n_drawn = 1'b1;
                    end
                end else begin
                    n_char = shade_char(rd_shade);
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_res_valid <= n_res_valid;
        end
        r_cmd   <= n_cmd;
        r_drawn <= n_drawn;
        r_char  <= n_char;
    end

    assign o_res_valid = r_res_valid;
    assign o_drawn     = r_drawn;
    assign o_char_code = r_char;
    assign o_clearing  = (r_state == B_CLEAR);
endmodule

[design/torus_point_zbuffer_plotter_unit.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                 | Payload
// items    | in        | push / full               | action, cell_index, phi and theta sin/cos
// results  | out       | pop / empty               | drawn, char_code
// config   | in        | psel, penable, pwrite     | paddr, pwdata, prdata (rotation sin/cos)
//
// A plot item keeps full high from its transfer through 24 arithmetic steps (18 on one shared
// 22x22 multiplier) around a bit-serial 16-bit reciprocal, then projection and cell check.
// Clear, read and idle items keep it high only while their command is sent. Back-end plot and
// read add a wait state. After reset the store is swept; full stays high during the sweep.
// A two-entry command queue and the result register let either side stall independently.
module torus_point_zbuffer_plotter_unit import tpz_pkg::*; #(
    parameter int SCREEN_COLS = SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
    parameter int CELL_COUNT  = CELL_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  t_action            i_action,
    input  logic [10:0]        i_cell_index,
    input  logic signed [15:0] i_sin_phi,
    input  logic signed [15:0] i_cos_phi,
    input  logic signed [15:0] i_sin_theta,
    input  logic signed [15:0] i_cos_theta,
    output logic               empty,
    input  logic               pop,
    output logic               o_drawn,
    output logic [7:0]         o_char_code,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    t_rot r_rot;
    logic cfg_we, accept, front_ready, clearing;
    logic cmd_push, q_full, q_valid, q_pop, res_valid;
    t_cmd front_cmd, q_cmd;
    logic signed [15:0] rd_val;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot.sin_a <= 16'sd0;
            r_rot.cos_a <= 16'sd16384;
            r_rot.sin_b <= 16'sd0;
            r_rot.cos_b <= 16'sd16384;
        end else if (cfg_we) begin
            unique case (t_reg'(paddr[3:2]))
                REG_SIN_A: r_rot.sin_a <= pwdata[15:0];
                REG_COS_A: r_rot.cos_a <= pwdata[15:0];
                REG_SIN_B: r_rot.sin_b <= pwdata[15:0];
                default:   r_rot.cos_b <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_SIN_A: rd_val = r_rot.sin_a;
            REG_COS_A: rd_val = r_rot.cos_a;
            REG_SIN_B: rd_val = r_rot.sin_b;
            default:   rd_val = r_rot.cos_b;
        endcase
    end
    assign prdata = {{16{rd_val[15]}}, rd_val};

    assign full   = !front_ready || clearing;
    assign accept = push && !full;

    tpz_front #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS),
        .CELL_COUNT  (CELL_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_action     (i_action),
        .i_cell_index (i_cell_index),
        .i_sin_phi    (i_sin_phi),
        .i_cos_phi    (i_cos_phi),
        .i_sin_theta  (i_sin_theta),
        .i_cos_theta  (i_cos_theta),
        .i_rot        (r_rot),
        .o_ready      (front_ready),
        .o_cmd        (front_cmd),
        .o_cmd_push   (cmd_push),
        .i_cmd_full   (q_full)
    );

    tpz_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_valid (q_valid)
    );

    tpz_back #(
        .CELL_COUNT (CELL_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_res_valid (res_valid),
        .o_drawn     (o_drawn),
        .o_char_code (o_char_code),
        .o_clearing  (clearing)
    );

    assign empty = !res_valid;
endmodule

[design/tpz_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the torus point plotter, bound to the top level.
// Depends on torus_point_zbuffer_plotter_unit.
module tpz_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       o_drawn,
    input logic [7:0] o_char_code
);
    a_full_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("full low right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> full)
        else $error("item taken while previous one still in front end");

    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_drawn && o_char_code != 8'd0))
        else $error("result carries both drawn and a character");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_drawn) && $stable(o_char_code))
        else $error("waiting result changed");
endmodule

bind torus_point_zbuffer_plotter_unit tpz_checker u_tpz_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for torus_point_zbuffer_plotter_unit: plots, clears and reads screen
// cells under several rotation settings with random idling on both queue sides.
// Depends on tpz_pkg and the plotter RTL.
module tb_top;
    import tpz_pkg::*;

    typedef struct {
        t_action            act;
        logic [10:0]        idx;
        logic signed [15:0] sp, cp, st, ct;
    } t_item;

    typedef struct {
        logic       drawn;
        logic [7:0] chr;
    } t_pix;

    logic               i_clk = 0;
    logic               i_rst_n;
    logic               push, full, empty, pop;
    t_action            i_action;
    logic [10:0]        i_cell_index;
    logic signed [15:0] i_sin_phi, i_cos_phi, i_sin_theta, i_cos_theta;
    logic               o_drawn;
    logic [7:0]         o_char_code;
    logic               psel, penable, pwrite, pready;
    logic [3:0]         paddr;
    logic [31:0]        pwdata, prdata;

    torus_point_zbuffer_plotter_unit dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    t_item   pending_items[$];
    t_pix    expected_pix[$];
    int      drawn_cells[$];
    longint  rot_sa, rot_ca, rot_sb, rot_cb;
    bit [15:0] depth_mem[CELL_COUNT_DEF];
    bit [3:0]  shade_mem[CELL_COUNT_DEF];
    int      snd_idle, rcv_idle, mismatches;
    string   ramp = ".,-~:;=!*#$@";

    function automatic longint fq(longint p);
        return p >>> 14;
    endfunction

    function automatic longint tz29(longint p);
        return (p >= 0) ? (p >>> 29) : -((-p) >>> 29);
    endfunction

    function automatic logic plot_point(t_item it);
        longint c, l, f, d, h, ch, fe, fg, lh, t, u, v, den, dq, col, row, cd, lum, shd, pos;
        c = it.sp; l = it.cp; f = it.st; d = it.ct;
        h = d + 32768;
        ch = fq(c * h); fe = fq(f * rot_sa); fg = fq(f * rot_ca); lh = fq(l * h);
        t = fq(ch * rot_ca) - fe;
        u = fq(lh * rot_cb) - fq(t * rot_sb);
        v = fq(lh * rot_sb) + fq(t * rot_cb);
        den = fq(ch * rot_sa) + fg + 5 * 16384;
        if (den <= 0) return 0;
        dq = (64'sd1 << 29) / den;
        if (dq > 65535) dq = 65535;
        col = tz29((64'sd40 << 29) + 30 * dq * u);
        row = tz29((64'sd12 << 29) + 15 * dq * v);
        cd = fq(c * d);
        lum = fq((fe - fq(cd * rot_ca)) * rot_cb) - fq(cd * rot_sa) - fg
              - fq(fq(l * d) * rot_sb);
        shd = (lum > 0) ? ((8 * lum) >>> 14) : 0;
        if (shd > 11) shd = 11;
        if (!(row > 0 && row < 22 && col > 0 && col < 80)) return 0;
        pos = col + 80 * row;
        if (pos >= CELL_COUNT_DEF) return 0;
        if (dq <= depth_mem[pos]) return 0;
        depth_mem[pos] = dq[15:0];
        shade_mem[pos] = shd[3:0];
        if (drawn_cells.size() < 64) drawn_cells.push_back(int'(pos));
        else drawn_cells[$urandom_range(63)] = int'(pos);
        return 1;
    endfunction

    function automatic void predict_pixel(t_item it);
        t_pix r;
        r.drawn = 0;
        r.chr = 0;
        case (it.act)
            ACT_CLEAR: if (it.idx < CELL_COUNT_DEF) begin
                depth_mem[it.idx] = 0;
                shade_mem[it.idx] = BLANK_SHADE;
            end
            ACT_PLOT: r.drawn = plot_point(it);
            ACT_READ: r.chr = (it.idx < CELL_COUNT_DEF && shade_mem[it.idx] < 12)
                              ? ramp[shade_mem[it.idx]] : 8'd32;
            default: ;
        endcase
        expected_pix.push_back(r);
    endfunction

    // transfer into the block
    always @(posedge i_clk) begin : driver
        logic go;
        if (!i_rst_n) begin
            push <= 0;
        end else begin
            if (push && !full) predict_pixel(pending_items.pop_front());
            go = pending_items.size() > 0 && ($urandom_range(99) >= snd_idle);
            push <= go;
            if (go) begin
                i_action     <= pending_items[0].act;
                i_cell_index <= pending_items[0].idx;
                i_sin_phi    <= pending_items[0].sp;
                i_cos_phi    <= pending_items[0].cp;
                i_sin_theta  <= pending_items[0].st;
                i_cos_theta  <= pending_items[0].ct;
            end
        end
    end

    // transfer out of the block
    always @(posedge i_clk) begin : monitor
        t_pix w;
        if (!i_rst_n) begin
            pop <= 0;
        end else begin
            if (pop && !empty) begin
                if (expected_pix.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %0d %0d", o_drawn, o_char_code);
                end else begin
                    w = expected_pix.pop_front();
                    if (w.drawn !== o_drawn || w.chr !== o_char_code) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp drawn %0d char %0d, got drawn %0d char %0d",
                                     w.drawn, w.chr, o_drawn, o_char_code);
                    end
                end
            end
            pop <= ($urandom_range(99) >= rcv_idle);
        end
    end

    task automatic write_reg(t_reg r, logic signed [15:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {r, 2'b00}; pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0;
        case (r)
            REG_SIN_A: rot_sa = val;
            REG_COS_A: rot_ca = val;
            REG_SIN_B: rot_sb = val;
            default:   rot_cb = val;
        endcase
    endtask

    task automatic set_rotation(int sa, int ca, int sb, int cb);
        write_reg(REG_SIN_A, 16'(sa));
        write_reg(REG_COS_A, 16'(ca));
        write_reg(REG_SIN_B, 16'(sb));
        write_reg(REG_COS_B, 16'(cb));
    endtask

    task automatic random_rotation();
        real a, b;
        a = $urandom_range(62831) / 10000.0;
        b = $urandom_range(62831) / 10000.0;
        set_rotation(int'($sin(a) * 16384), int'($cos(a) * 16384),
                     int'($sin(b) * 16384), int'($cos(b) * 16384));
    endtask

    task automatic add(t_action a, int idx, int sp, int cp, int st, int ct);
        t_item it;
        it.act = a; it.idx = 11'(idx);
        it.sp = 16'(sp); it.cp = 16'(cp); it.st = 16'(st); it.ct = 16'(ct);
        pending_items.push_back(it);
    endtask

    task automatic add_random();
        real p, q;
        int k;
        k = $urandom_range(99);
        p = $urandom_range(62831) / 10000.0;
        q = $urandom_range(62831) / 10000.0;
        if (k < 66)
            add(ACT_PLOT, $urandom, int'($sin(p) * 16384), int'($cos(p) * 16384),
                int'($sin(q) * 16384), int'($cos(q) * 16384));
        else if (k < 70)
            add(ACT_PLOT, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (k < 82 && drawn_cells.size() > 0)
            add(ACT_READ, drawn_cells[$urandom_range(drawn_cells.size() - 1)],
                $urandom, $urandom, $urandom, $urandom);
        else if (k < 88)
            add(ACT_READ, $urandom_range(2047), $urandom, $urandom, $urandom, $urandom);
        else if (k < 96)
            add(ACT_CLEAR, (k < 94 && drawn_cells.size() > 0)
                ? drawn_cells[$urandom_range(drawn_cells.size() - 1)] : $urandom_range(2047),
                $urandom, $urandom, $urandom, $urandom);
        else
            add(ACT_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_pix.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n <= 0; psel <= 0; penable <= 0; pwrite <= 0; paddr <= 0; pwdata <= 0;
        i_action <= ACT_NONE; i_cell_index <= 0;
        i_sin_phi <= 0; i_cos_phi <= 0; i_sin_theta <= 0; i_cos_theta <= 0;
        snd_idle = 0; rcv_idle = 0; mismatches = 0;
        rot_sa = 0; rot_ca = 16384; rot_sb = 0; rot_cb = 16384;
        foreach (depth_mem[i]) begin
            depth_mem[i] = 0;
            shade_mem[i] = BLANK_SHADE;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        set_rotation(0, 16384, 0, 16384);
        add(ACT_READ, 100, 0, 0, 0, 0);
        add(ACT_PLOT, 0, 0, 0, 0, 0);
        add(ACT_PLOT, 0, 0, 0, 0, 0);
        add(ACT_PLOT, 0, 16384, 0, 0, -16384);
        add(ACT_PLOT, 0, -16384, 0, 0, 16384);
        add(ACT_PLOT, 0, 0, 16384, 16384, 0);
        add(ACT_PLOT, 0, 0, -16384, -16384, 0);
        add(ACT_PLOT, 0, 32767, -32768, 32767, -32768);
        add(ACT_PLOT, 0, -32768, 32767, -32768, 32767);
        add(ACT_READ, 12 * 80 + 40, 0, 0, 0, 0);
        add(ACT_CLEAR, 12 * 80 + 40, 0, 0, 0, 0);
        add(ACT_READ, 12 * 80 + 40, 0, 0, 0, 0);
        add(ACT_CLEAR, 2047, 0, 0, 0, 0);
        add(ACT_READ, 1760, 0, 0, 0, 0);
        add(ACT_READ, 1759, 0, 0, 0, 0);
        add(ACT_READ, 0, 0, 0, 0, 0);
        add(ACT_NONE, 2047, -1, -1, -1, -1);
        drain();
        // point behind the viewer
        set_rotation(-16384, 0, 16384, 0);
        add(ACT_PLOT, 0, 32767, 0, 0, 32767);
        add(ACT_PLOT, 0, 16384, 0, 0, 16384);
        add(ACT_PLOT, 0, 0, 16384, -16384, 0);
        drain();
        set_rotation(16384, -16384, -16384, -16384);
        add(ACT_PLOT, 0, 0, 16384, 16384, 0);
        add(ACT_PLOT, 0, -16384, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle = (ph == 0) ? 32 : (ph == 1) ? 87 : 0;
            rcv_idle = (ph == 0) ? 87 : (ph == 1) ? 32 : 0;
            for (int s = 0; s < 2; s++) begin
                if (ph == 1 && s == 0) set_rotation(-16384, 16384, 16384, -16384);
                else random_rotation();
                repeat (125) add_random();
                drain();
            end
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
